// ===== hw/rtl/arc_pkg.sv =====
// Shared types, codes and helper functions for the ASCII radix converter.
`timescale 1ns / 1ps
`default_nettype none

package arc_pkg;

  // Numeric radix as the datapath sees it. Register code three maps to hexadecimal.
  typedef enum logic [1:0] {
    RADIX_BIN,
    RADIX_DEC,
    RADIX_HEX
  } radix_t;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_READ,
    ST_EMIT
  } state_t;

  // Steps of the decimal digit extraction.
  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_FOLD,
    DIV_REM,
    DIV_FIX
  } div_state_t;

  localparam int DIGIT_W = 4;

  // Status returned by the digit extraction unit.
  typedef struct packed {
    logic               done;
    logic [DIGIT_W-1:0] rem;
  } div_status_t;

  // Configuration register indexes.
  localparam logic REG_INPUT_RADIX  = 1'b0;
  localparam logic REG_OUTPUT_RADIX = 1'b1;

  localparam logic [1:0] CODE_BIN = 2'd0;
  localparam logic [1:0] CODE_DEC = 2'd1;
  localparam logic [1:0] CODE_HEX = 2'd2;

  localparam logic [1:0] INPUT_RADIX_RESET  = CODE_HEX;
  localparam logic [1:0] OUTPUT_RADIX_RESET = CODE_BIN;

  localparam logic [7:0] ASCII_ZERO     = 8'd48;
  localparam logic [7:0] ASCII_UPPER_A  = 8'd65;
  localparam logic [7:0] ASCII_UPPER_F  = 8'd70;
  localparam logic [7:0] ASCII_LOWER_A  = 8'd97;
  localparam logic [7:0] ASCII_LOWER_F  = 8'd102;
  localparam logic [7:0] UPPER_OFFSET   = 8'd55;
  localparam logic [7:0] LOWER_OFFSET   = 8'd87;

  localparam logic [DIGIT_W:0] DEC_DIVISOR = 5'd10;
  localparam logic [DIGIT_W-1:0] DEC_LIMIT = 4'd10;

  function automatic radix_t radix_of(input logic [1:0] code);
    radix_t r;
    unique case (code)
      CODE_BIN: r = RADIX_BIN;
      CODE_DEC: r = RADIX_DEC;
      default:  r = RADIX_HEX;
    endcase
    return r;
  endfunction

  // ASCII code of one output digit, lower-case letters above nine.
  function automatic logic [7:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [7:0] c;
    if (d < DEC_LIMIT) begin
      c = ASCII_ZERO + {4'd0, d};
    end else begin
      c = LOWER_OFFSET + {4'd0, d};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/arc_divider.sv =====
// Digit extraction unit: quotient and remainder of a value by the output radix.
`timescale 1ns / 1ps
`default_nettype none

module arc_divider import arc_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire radix_t                radix,
  input  wire logic [VALUE_BITS-1:0] dividend,
  output logic [VALUE_BITS-1:0]      quotient,
  output div_status_t                status
);

  // The decimal quotient is estimated as n * 0.8 / 8 by folding shifted
  // copies of the estimate onto itself; the shift starts at four and doubles
  // while it stays below VALUE_BITS. The estimate is low by at most one.
  localparam int SW         = $clog2(2 * VALUE_BITS + 1);
  localparam int FIRST_FOLD = 4;

  div_state_t div_state;
  div_state_t div_state_next;

  logic [VALUE_BITS-1:0] num;
  logic [VALUE_BITS-1:0] quo;
  logic [DIGIT_W:0]      rem;
  logic [SW-1:0]         fold_shift;
  logic                  done;

  logic [VALUE_BITS-1:0] q_est;
  logic [VALUE_BITS-1:0] rem_full;
  logic                  last_fold;

  assign q_est     = quo >> 3;
  assign rem_full  = num - ((q_est << 3) + (q_est << 1));
  assign last_fold = ((fold_shift << 1) >= SW'(VALUE_BITS));

  always_comb begin
    div_state_next = div_state;
    unique case (div_state)
      DIV_IDLE: begin
        if (start && radix == RADIX_DEC) begin
          div_state_next = DIV_FOLD;
        end
      end
      DIV_FOLD: begin
        if (last_fold) begin
          div_state_next = DIV_REM;
        end
      end
      DIV_REM: div_state_next = DIV_FIX;
      DIV_FIX: div_state_next = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_state <= DIV_IDLE;
    end else begin
      div_state <= div_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (div_state)
        DIV_IDLE: begin
          if (start) begin
            unique case (radix)
              RADIX_BIN: begin
                quo  <= dividend >> 1;
                rem  <= {{DIGIT_W{1'b0}}, dividend[0]};
                done <= 1'b1;
              end
              RADIX_DEC: begin
                num        <= dividend;
                quo        <= (dividend >> 1) + (dividend >> 2);
                fold_shift <= SW'(FIRST_FOLD);
              end
              default: begin
                quo  <= dividend >> DIGIT_W;
                rem  <= {1'b0, dividend[DIGIT_W-1:0]};
                done <= 1'b1;
              end
            endcase
          end
        end
        DIV_FOLD: begin
          quo        <= quo + (quo >> fold_shift);
          fold_shift <= fold_shift << 1;
        end
        DIV_REM: begin
          quo <= q_est;
          rem <= rem_full[DIGIT_W:0];
        end
        DIV_FIX: begin
          if (rem >= DEC_DIVISOR) begin
            quo <= quo + 1'b1;
            rem <= rem - DEC_DIVISOR;
          end
          done <= 1'b1;
        end
      endcase
    end
  end

  assign quotient    = quo;
  assign status.done = done;
  assign status.rem  = rem[DIGIT_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/ascii_radix_converter.sv =====
// Top level of the ASCII radix converter: input handshake, sequencer and digit stack.
`timescale 1ns / 1ps
`default_nettype none

// The block takes an ASCII number string one character per transaction
// (start high while busy is low) and accumulates it in the input radix, one
// cycle per character, with busy staying low. When both radixes name the same
// base, every character is echoed on the result ports in the cycle after it is
// taken. Otherwise, on the character marked last the block turns busy and
// converts: each output digit passes through a start state and then waits on
// the shared extraction unit, which for binary or hexadecimal needs only a
// shift. For decimal the unit folds a shift-and-add estimate of the quotient
// (three steps at 32 bits), takes one remainder step and one correction step,
// and reports in the cycle after. Each digit then comes off the digit stack
// memory, whose read port is registered, through a read and an emit state.
// Results appear for exactly one cycle with strobe high; the receiver cannot
// hold them off, so it must sample every strobe.
// The last digit is marked by last_out, and busy falls as that digit is shown.
// Configuration should be written only while busy is low.

module ascii_radix_converter import arc_pkg::*; #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_DIGITS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [7:0] char_code,
  input  wire logic       last_char,
  input  wire logic       wr_en,
  input  wire logic       wr_index,
  input  wire logic [1:0] wr_data,
  output logic            strobe,
  output logic [7:0]      out_char,
  output logic            last_out
);

  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int AW = $clog2(MAX_DIGITS);

  logic [1:0] input_radix;
  logic [1:0] output_radix;

  state_t state;
  state_t state_next;

  logic [VALUE_BITS-1:0] value;
  logic [CW-1:0]         count;

  // Digit stack, filled least significant digit first.
  logic [DIGIT_W-1:0] stack [MAX_DIGITS];
  logic [DIGIT_W-1:0] rd_data;

  radix_t rin;
  radix_t rout;
  logic   echo;
  logic   accept;

  assign rin    = radix_of(input_radix);
  assign rout   = radix_of(output_radix);
  assign echo   = (rin == rout);
  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // The digit value of the incoming character; codes below '0' wrap around.
  logic [VALUE_BITS-1:0] digit;
  logic [VALUE_BITS-1:0] scaled;
  logic [VALUE_BITS-1:0] value_next;

  always_comb begin
    digit = VALUE_BITS'(char_code) - VALUE_BITS'(ASCII_ZERO);
    if (rin == RADIX_HEX) begin
      if (char_code >= ASCII_UPPER_A && char_code <= ASCII_UPPER_F) begin
        digit = VALUE_BITS'(char_code - UPPER_OFFSET);
      end else if (char_code >= ASCII_LOWER_A && char_code <= ASCII_LOWER_F) begin
        digit = VALUE_BITS'(char_code - LOWER_OFFSET);
      end
    end
    // Multiplication by the radix is a shift, or two shifts and an add for ten.
    unique case (rin)
      RADIX_BIN: scaled = value << 1;
      RADIX_DEC: scaled = (value << 3) + (value << 1);
      default:   scaled = value << 4;
    endcase
    value_next = scaled + digit;
  end

  // Shared extraction unit.
  logic                  div_start;
  logic [VALUE_BITS-1:0] quotient;
  div_status_t           div_status;

  assign div_start = (state == ST_START);

  arc_divider #(
    .VALUE_BITS(VALUE_BITS)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .radix    (rout),
    .dividend (value),
    .quotient (quotient),
    .status   (div_status)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      input_radix  <= INPUT_RADIX_RESET;
      output_radix <= OUTPUT_RADIX_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_INPUT_RADIX:  input_radix  <= wr_data;
        REG_OUTPUT_RADIX: output_radix <= wr_data;
      endcase
    end
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && last_char && !echo) begin
          state_next = ST_START;
        end
      end
      ST_START: state_next = ST_DIV;
      ST_DIV: begin
        if (div_status.done) begin
          state_next = (quotient == '0) ? ST_READ : ST_START;
        end
      end
      ST_READ: state_next = ST_EMIT;
      ST_EMIT: state_next = (count == '0) ? ST_IDLE : ST_READ;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Accumulated value and digit count.
  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
      count <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (echo) begin
              if (last_char) begin
                value <= '0;
                count <= '0;
              end
            end else begin
              value <= value_next;
            end
          end
        end
        ST_DIV: begin
          if (div_status.done) begin
            value <= quotient;
            if (count < CW'(MAX_DIGITS)) begin
              count <= count + 1'b1;
            end
          end
        end
        ST_READ: count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  // Stack memory: one write port for extracted digits, one registered read port.
  always_ff @(posedge clk) begin
    if (state == ST_DIV && div_status.done && count < CW'(MAX_DIGITS)) begin
      stack[count[AW-1:0]] <= div_status.rem;
    end
  end

  logic [CW-1:0] rd_index;
  assign rd_index = count - 1'b1;

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      rd_data <= stack[rd_index[AW-1:0]];
    end
  end

  // Result register: each result is shown for one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (accept && echo) || (state == ST_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT) begin
      out_char <= digit_to_ascii(rd_data);
      last_out <= (count == '0);
    end else if (accept && echo) begin
      out_char <= char_code;
      last_out <= last_char;
    end
  end

endmodule

`default_nettype wire

// ===== test/tb_ascii_radix_converter.sv =====
// Self-checking testbench for the ASCII radix converter, with a scoreboard that predicts every digit.
`timescale 1ns / 1ps

// Each character that the block takes is noted in the scoreboard, which
// follows both radix registers and the running value and queues what the
// block should emit: every character in echo mode, else a string's digits
// at its end. Each strobe pops the oldest entry and compares both fields.
// The run opens with a short directed part: all-ones values, zero, the
// extreme character codes, echo mode, register code three and a letter in
// decimal input. After that come twelve phases of random strings, one radix
// setting per phase. Most strings are well formed; some overflow 32 bits,
// some carry a stray character and some are pure noise. The sender idles
// often in the first phases, more often in the middle ones and never in the
// last ones. The results cannot be held off, so only the sender has gaps.

module tb_ascii_radix_converter import arc_pkg::*;;

  localparam int          NUM_PHASES     = 12;
  localparam int unsigned PHASE_ITEMS    = 24;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  // Register code three is not named in the package. The block reads it as
  // hexadecimal.
  localparam logic [1:0] CODE_ALT_HEX = 2'd3;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } out_digit_t;

  // Tracks the radix registers and the running value. Each accepted character
  // queues the digits that it should produce.
  class radix_tracker;
    logic [1:0]  in_code  = INPUT_RADIX_RESET;
    logic [1:0]  out_code = OUTPUT_RADIX_RESET;
    logic [31:0] value    = '0;
    out_digit_t  pending_digits[$];
    int unsigned errors   = 0;

    static function radix_t base_of(logic [1:0] code);
      case (code)
        CODE_BIN: return RADIX_BIN;
        CODE_DEC: return RADIX_DEC;
        default:  return RADIX_HEX;
      endcase
    endfunction

    static function int unsigned base_num(radix_t r);
      case (r)
        RADIX_BIN: return 2;
        RADIX_DEC: return 10;
        default:   return 16;
      endcase
    endfunction

    function void write_reg(logic idx, logic [1:0] data);
      if (idx == REG_INPUT_RADIX) begin
        in_code = data;
      end else begin
        out_code = data;
      end
    endfunction

    function void take_char(logic [7:0] c, logic fin);
      radix_t               rin;
      radix_t               rout;
      logic [31:0]          digit;
      logic [31:0]          rest;
      logic [DIGIT_W-1:0]   stack[$];
      out_digit_t           item;
      rin  = base_of(in_code);
      rout = base_of(out_code);
      // With equal radixes every character comes straight back.
      if (rin == rout) begin
        item.ch  = c;
        item.fin = fin;
        pending_digits.push_back(item);
        if (fin) begin
          value = '0;
        end
        return;
      end
      // Letters count as digits only in hexadecimal input. Everything else
      // is its code minus the code of zero, wrapping below zero.
      if (rin == RADIX_HEX && c >= ASCII_UPPER_A && c <= ASCII_UPPER_F) begin
        digit = 32'(c - ASCII_UPPER_A) + 32'd10;
      end else if (rin == RADIX_HEX && c >= ASCII_LOWER_A && c <= ASCII_LOWER_F) begin
        digit = 32'(c - ASCII_LOWER_A) + 32'd10;
      end else begin
        digit = {24'd0, c} - {24'd0, ASCII_ZERO};
      end
      value = value * base_num(rin) + digit;
      if (!fin) begin
        return;
      end
      // Most significant digit first; a zero value still gives one digit.
      rest = value;
      do begin
        stack.push_front(DIGIT_W'(rest % base_num(rout)));
        rest = rest / base_num(rout);
      end while (rest != 0);
      foreach (stack[i]) begin
        item.ch  = (stack[i] < 4'd10) ? ASCII_ZERO + {4'd0, stack[i]}
                                      : LOWER_OFFSET + {4'd0, stack[i]};
        item.fin = (i == stack.size() - 1);
        pending_digits.push_back(item);
      end
      value = '0;
    endfunction

    function void check_digit(logic [7:0] c, logic fin);
      out_digit_t exp_item;
      if (pending_digits.size() == 0) begin
        $error("unexpected result: out_char=%0h last_out=%0b", c, fin);
        errors++;
        return;
      end
      exp_item = pending_digits.pop_front();
      if (c !== exp_item.ch) begin
        $error("out_char: expected %0h, actual %0h", exp_item.ch, c);
        errors++;
      end
      if (fin !== exp_item.fin) begin
        $error("last_out: expected %0b, actual %0b", exp_item.fin, fin);
        errors++;
      end
    endfunction
  endclass

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       start     = 1'b0;
  logic       busy;
  logic [7:0] char_code = '0;
  logic       last_char = 1'b0;
  logic       wr_en     = 1'b0;
  logic       wr_index  = REG_INPUT_RADIX;
  logic [1:0] wr_data   = '0;
  logic       strobe;
  logic [7:0] out_char;
  logic       last_out;

  radix_tracker tracker      = new();
  int unsigned  items_sent   = 0;
  int unsigned  idle_pct     = 27;
  int unsigned  quiet_cycles = 0;

  ascii_radix_converter i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .char_code (char_code),
    .last_char (last_char),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .strobe    (strobe),
    .out_char  (out_char),
    .last_out  (last_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Everything is sampled at the rising edge, before the block's own updates
  // land, so a transaction is seen exactly as the block sees it. The same
  // block runs the watchdog, which counts edges that move nothing at all.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (wr_en) begin
        tracker.write_reg(wr_index, wr_data);
      end
      if (start && !busy) begin
        tracker.take_char(char_code, last_char);
      end
      if (strobe) begin
        tracker.check_digit(out_char, last_out);
      end
      if (wr_en || (start && !busy) || strobe) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("FAIL ascii_radix_converter");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Radix codes of each random phase, input in the upper two bits. Two
  // equal-radix settings, hex and binary, and code three in either register are among them.
  function automatic logic [3:0] phase_setting(int p);
    case (p)
      0:       return {CODE_BIN, CODE_DEC};
      1:       return {CODE_HEX, CODE_BIN};
      2:       return {CODE_DEC, CODE_HEX};
      3:       return {CODE_ALT_HEX, CODE_DEC};
      4:       return {CODE_BIN, CODE_HEX};
      5:       return {CODE_DEC, CODE_BIN};
      6:       return {CODE_HEX, CODE_HEX};
      7:       return {CODE_BIN, CODE_ALT_HEX};
      8:       return {CODE_DEC, CODE_ALT_HEX};
      9:       return {CODE_ALT_HEX, CODE_BIN};
      10:      return {CODE_BIN, CODE_BIN};
      default: return {CODE_HEX, CODE_DEC};
    endcase
  endfunction

  // A random digit of the given radix, or its highest digit. Hex letters
  // come in either case.
  function automatic logic [7:0] pick_digit(radix_t r, bit top);
    int unsigned d;
    case (r)
      RADIX_BIN: d = top ? 1 : $urandom_range(1);
      RADIX_DEC: d = top ? 9 : $urandom_range(9);
      default:   d = top ? 15 : $urandom_range(15);
    endcase
    if (d < 10) begin
      return ASCII_ZERO + 8'(d);
    end else if ($urandom_range(1) == 1) begin
      return ASCII_UPPER_A + 8'(d - 10);
    end else begin
      return ASCII_LOWER_A + 8'(d - 10);
    end
  endfunction

  // One character transaction. The sender may idle first; start stays high
  // until busy is low at an edge.
  task automatic send_char(input logic [7:0] c, input logic fin);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    char_code <= c;
    last_char <= fin;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], i == s.len() - 1);
    end
  endtask

  // Strings are mostly well formed, with random content and often short.
  // The rest are full-width strings of the top digit, strings long enough to
  // wrap past 32 bits, strings with one stray character, and pure noise.
  task automatic send_random_string(input radix_t r);
    int unsigned kind;
    int unsigned len;
    int unsigned full;
    int unsigned noise_at;
    kind = $urandom_range(99);
    full = (r == RADIX_BIN) ? 32 : (r == RADIX_DEC) ? 10 : 8;
    if (kind < 12) begin
      len = $urandom_range(1, 4);
      for (int i = 0; i < len; i++) begin
        send_char(8'($urandom_range(255)), i == len - 1);
      end
    end else if (kind < 22) begin
      for (int i = 0; i < full; i++) begin
        send_char(pick_digit(r, 1'b1), i == full - 1);
      end
    end else begin
      len = ($urandom_range(1) == 1) ? $urandom_range(1, 8) : $urandom_range(1, full);
      if ($urandom_range(9) == 0) begin
        len += 3;
      end
      noise_at = ($urandom_range(6) == 0) ? $urandom_range(len - 1) : len;
      for (int i = 0; i < len; i++) begin
        send_char((i == noise_at) ? 8'($urandom_range(255)) : pick_digit(r, 1'b0),
                  i == len - 1);
      end
    end
  endtask

  // Waits until every queued digit has come out and the block is idle, then
  // lets it settle before anything else changes.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (busy || tracker.pending_digits.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [1:0] in_code, input logic [1:0] out_code);
    wr_en    <= 1'b1;
    wr_index <= REG_INPUT_RADIX;
    wr_data  <= in_code;
    @(posedge clk);
    wr_index <= REG_OUTPUT_RADIX;
    wr_data  <= out_code;
    @(posedge clk);
    wr_en    <= 1'b0;
  endtask

  initial begin
    int unsigned phase_start;
    logic [3:0]  setting;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset setting is hex in, binary out: all ones in mixed case, zero, and
    // the two extreme codes as non-digits.
    send_text("FFFFffff");
    send_text("0");
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    // Equal radixes echo the characters, extremes included.
    drain();
    configure(CODE_DEC, CODE_DEC);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    // Code three in the input register equals hexadecimal output: echo.
    drain();
    configure(CODE_ALT_HEX, CODE_HEX);
    send_text("7");
    // Code three in the output register converts to hexadecimal.
    drain();
    configure(CODE_BIN, CODE_ALT_HEX);
    send_text("10");
    // A letter in decimal input is just its code minus the code of zero.
    drain();
    configure(CODE_DEC, CODE_BIN);
    send_text("a");
    // The largest value in decimal output, the slowest radix per digit.
    drain();
    configure(CODE_HEX, CODE_DEC);
    send_text("ffffffff");

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      setting = phase_setting(p);
      configure(setting[3:2], setting[1:0]);
      idle_pct    = (p < 4) ? 27 : (p < 8) ? 55 : 0;
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        send_random_string(radix_tracker::base_of(setting[3:2]));
      end
    end
    drain();

    if (tracker.errors == 0 && tracker.pending_digits.size() == 0) begin
      $display("PASS ascii_radix_converter");
    end else begin
      $display("FAIL ascii_radix_converter");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/arc_pkg.sv
hw/rtl/arc_divider.sv
hw/rtl/ascii_radix_converter.sv
test/tb_ascii_radix_converter.sv
